@@ hdl/ppp_pkg.sv @@
// shared constants, register codes and width helpers for the point projector
`default_nettype none

package ppp_pkg;

  // fixed point and field widths
  localparam int FRACTION_BITS_DEF = 16;
  localparam int DATA_W            = 32;
  localparam int SIZE_W            = 14;
  localparam int CFG_W             = 64;
  localparam int ADDR_W            = 6;
  localparam int REG_IDX_W         = 3;

  // quotient is capped at 2^QUOT_BITS
  localparam int QUOT_BITS           = 40;
  localparam int DIV_STEPS_PER_STAGE = 2;
  localparam int DIV_STAGES          = QUOT_BITS / DIV_STEPS_PER_STAGE;
  localparam int DIV_LAT             = DIV_STAGES + 1;

  // pipeline depths of the parts, edges from accept to result transaction
  localparam int MAT_LAT   = 2;
  localparam int PREP_LAT  = 1;
  localparam int VP_LAT    = 1;
  localparam int OUT_LAT   = 1;
  localparam int TOTAL_LAT = MAT_LAT + PREP_LAT + DIV_LAT + VP_LAT + OUT_LAT;

  // behind-camera scaling
  localparam int BEHIND_SCALE = 100000;
  localparam int BEHIND_LIMIT = 2147483647 / BEHIND_SCALE + 1;
  localparam int BEHIND_IN_W  = 16;

  localparam logic signed [DATA_W-1:0] PIX_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] PIX_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_X_FIRST  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_X_SECOND = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_Y_FIRST  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_Y_SECOND = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_W_FIRST  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_W_SECOND = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_WIDTH    = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_HEIGHT   = 3'd7;

  localparam logic [SIZE_W-1:0] SCREEN_WIDTH_RST  = 14'd1920;
  localparam logic [SIZE_W-1:0] SCREEN_HEIGHT_RST = 14'd1080;

  // width of a signed row sum for a given number of fraction bits
  function automatic int sum_width(input int frac);
    return 66 - frac;
  endfunction

endpackage

`default_nettype wire

@@ hdl/ppp_matrix.sv @@
// two-stage matrix unit: nine products, then three row sums
`default_nettype none

module ppp_matrix
  import ppp_pkg::*;
#(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        valid_i,
  input  logic signed [DATA_W-1:0]                    world_x_i,
  input  logic signed [DATA_W-1:0]                    world_y_i,
  input  logic signed [DATA_W-1:0]                    world_z_i,
  input  logic [2:0][CFG_W-1:0]                       first_pair_i,
  input  logic [2:0][CFG_W-1:0]                       second_pair_i,
  output logic                                        valid_o,
  output logic signed [sum_width(FRACTION_BITS)-1:0]  clip_x_o,
  output logic signed [sum_width(FRACTION_BITS)-1:0]  clip_y_o,
  output logic signed [sum_width(FRACTION_BITS)-1:0]  clip_w_o
);

  localparam int SUM_W  = sum_width(FRACTION_BITS);
  localparam int ROWS   = 3;
  localparam int COLS   = 3;
  localparam int PROD_W = 2 * DATA_W;

  logic signed [DATA_W-1:0]   coord  [COLS];
  logic signed [2*DATA_W-1:0] prod_d [ROWS][COLS];
  logic signed [2*DATA_W-1:0] prod_q [ROWS][COLS];
  logic signed [DATA_W-1:0]   bias_q [ROWS];
  logic signed [SUM_W-1:0]    sum_d  [ROWS];
  logic signed [SUM_W-1:0]    sum_q  [ROWS];
  logic signed [2*DATA_W-1:0] shifted;
  logic                       valid_a_q;
  logic                       valid_b_q;

  always_comb begin
    coord[0] = world_x_i;
    coord[1] = world_y_i;
    coord[2] = world_z_i;
    for (int r = 0; r < ROWS; r++) begin
      prod_d[r][0] = PROD_W'($signed(first_pair_i[r][DATA_W-1:0]))
                   * PROD_W'(coord[0]);
      prod_d[r][1] = PROD_W'($signed(first_pair_i[r][CFG_W-1:DATA_W]))
                   * PROD_W'(coord[1]);
      prod_d[r][2] = PROD_W'($signed(second_pair_i[r][DATA_W-1:0]))
                   * PROD_W'(coord[2]);
    end
  end

  // floor shift of each product, column 3 added as is
  always_comb begin
    shifted = '0;
    for (int r = 0; r < ROWS; r++) begin
      sum_d[r] = {{(SUM_W-DATA_W){bias_q[r][DATA_W-1]}}, bias_q[r]};
      for (int c = 0; c < COLS; c++) begin
        shifted  = prod_q[r][c] >>> FRACTION_BITS;
        sum_d[r] = sum_d[r] + $signed(shifted[SUM_W-1:0]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int r = 0; r < ROWS; r++) begin
      for (int c = 0; c < COLS; c++) begin
        prod_q[r][c] <= prod_d[r][c];
      end
      bias_q[r] <= $signed(second_pair_i[r][CFG_W-1:DATA_W]);
      sum_q[r]  <= sum_d[r];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_b_q <= 1'b0;
    end else begin
      valid_a_q <= valid_i;
      valid_b_q <= valid_a_q;
    end
  end

  assign valid_o  = valid_b_q;
  assign clip_x_o = sum_q[0];
  assign clip_y_o = sum_q[1];
  assign clip_w_o = sum_q[2];

endmodule

`default_nettype wire

@@ hdl/ppp_div.sv @@
// pipelined restoring divider: capped floor(mag * 2^f / den), two bits per stage
`default_nettype none

module ppp_div
  import ppp_pkg::*;
#(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic [sum_width(FRACTION_BITS)-1:0]  mag_i,
  input  logic [sum_width(FRACTION_BITS)-1:0]  den_i,
  output logic [QUOT_BITS:0]                   quot_o
);

  localparam int SUM_W = sum_width(FRACTION_BITS);
  localparam int SHIFT = QUOT_BITS - FRACTION_BITS;
  localparam int CMP_W = SUM_W + SHIFT;

  logic [SUM_W-1:0]     rem_q  [DIV_STAGES+1];
  logic [SUM_W-1:0]     den_q  [DIV_STAGES+1];
  logic [QUOT_BITS-1:0] low_q  [DIV_STAGES+1];
  logic [QUOT_BITS-1:0] quot_q [DIV_STAGES+1];
  logic                 cap_q  [DIV_STAGES+1];

  logic [SUM_W-1:0]     rem_d  [DIV_STAGES];
  logic [QUOT_BITS-1:0] low_d  [DIV_STAGES];
  logic [QUOT_BITS-1:0] quot_d [DIV_STAGES];
  logic [SUM_W-1:0]     trial;

  // each stage retires two quotient bits
  always_comb begin
    trial = '0;
    for (int k = 0; k < DIV_STAGES; k++) begin
      rem_d[k]  = rem_q[k];
      low_d[k]  = low_q[k];
      quot_d[k] = quot_q[k];
      for (int j = 0; j < DIV_STEPS_PER_STAGE; j++) begin
        trial    = {rem_d[k][SUM_W-2:0], low_d[k][QUOT_BITS-1]};
        low_d[k] = {low_d[k][QUOT_BITS-2:0], 1'b0};
        if (trial >= den_q[k]) begin
          rem_d[k]  = trial - den_q[k];
          quot_d[k] = {quot_d[k][QUOT_BITS-2:0], 1'b1};
        end else begin
          rem_d[k]  = trial;
          quot_d[k] = {quot_d[k][QUOT_BITS-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    // quotient reaches the cap exactly when mag >= den * 2^(QUOT_BITS - f)
    cap_q[0]  <= CMP_W'(mag_i) >= {den_i, {SHIFT{1'b0}}};
    rem_q[0]  <= mag_i >> SHIFT;
    low_q[0]  <= {mag_i[SHIFT-1:0], {FRACTION_BITS{1'b0}}};
    den_q[0]  <= den_i;
    quot_q[0] <= '0;
    for (int k = 0; k < DIV_STAGES; k++) begin
      cap_q[k+1]  <= cap_q[k];
      rem_q[k+1]  <= rem_d[k];
      low_q[k+1]  <= low_d[k];
      den_q[k+1]  <= den_q[k];
      quot_q[k+1] <= quot_d[k];
    end
  end

  assign quot_o = cap_q[DIV_STAGES] ? {1'b1, {QUOT_BITS{1'b0}}}
                                    : {1'b0, quot_q[DIV_STAGES]};

endmodule

`default_nettype wire

@@ hdl/ppp_viewport.sv @@
// viewport map of one coordinate: offset product, then centre add with saturation
`default_nettype none

module ppp_viewport
  import ppp_pkg::*;
#(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic [QUOT_BITS:0]       quot_i,
  input  logic                     sub_i,
  input  logic [SIZE_W-1:0]        size_i,
  output logic signed [DATA_W-1:0] pixel_o
);

  localparam int PROD_W = QUOT_BITS + 1 + SIZE_W;
  localparam int ACC_W  = PROD_W + 1;

  logic [PROD_W-1:0]       prod_q;
  logic                    sub_q;
  logic signed [ACC_W-1:0] centre_ext;
  logic signed [ACC_W-1:0] off_ext;
  logic signed [ACC_W-1:0] acc;

  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(quot_i) * PROD_W'(size_i);
    sub_q  <= sub_i;
  end

  always_comb begin
    centre_ext = ACC_W'({size_i, {(FRACTION_BITS-1){1'b0}}});
    off_ext    = ACC_W'(prod_q[PROD_W-1:1]);
    acc        = sub_q ? centre_ext - off_ext : centre_ext + off_ext;
    if (&acc[ACC_W-1:DATA_W-1] || ~|acc[ACC_W-1:DATA_W-1]) begin
      pixel_o = acc[DATA_W-1:0];
    end else if (acc[ACC_W-1]) begin
      pixel_o = PIX_MIN;
    end else begin
      pixel_o = PIX_MAX;
    end
  end

endmodule

`default_nettype wire

@@ hdl/perspective_point_projector.sv @@
// top level of the perspective point projector: registers, pipeline and result stage
`default_nettype none

// Projects one world point per clock. A transaction is taken at every edge where
// start is high; busy never rises, so a new point may follow every cycle. Each
// point gives exactly one result: result_valid_o is high for a single cycle per
// point and the receiver cannot hold it off. The path runs through the divider
// (20 stages of two quotient bits each plus a cap-check stage), with two stages
// of matrix products and row sums, one preparation stage, one offset multiply
// and the output register around it. Matrix and screen size registers are read
// by points in flight, so write them only with no transaction in the pipeline.

module perspective_point_projector
  import ppp_pkg::*;
#(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // point channel
  input  logic                     start,
  output logic                     busy,
  input  logic signed [DATA_W-1:0] world_x_i,
  input  logic signed [DATA_W-1:0] world_y_i,
  input  logic signed [DATA_W-1:0] world_z_i,
  // result channel
  output logic                     result_valid_o,
  output logic signed [DATA_W-1:0] screen_x_o,
  output logic signed [DATA_W-1:0] screen_y_o,
  output logic                     in_front_o,
  // register port
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ADDR_W-1:0]        paddr,
  input  logic [CFG_W-1:0]         pwdata,
  output logic [CFG_W-1:0]         prdata,
  output logic                     pready
);

  localparam int SUM_W     = sum_width(FRACTION_BITS);
  localparam int SIDE_LAT  = DIV_LAT + VP_LAT;
  localparam int W_MIN_INT = ((1 << FRACTION_BITS) + 500) / 1000;

  // near threshold, 0.001 in fixed point
  localparam logic signed [SUM_W-1:0]  W_MIN   = SUM_W'(W_MIN_INT);
  localparam logic signed [SUM_W-1:0]  LIM_P   = SUM_W'(BEHIND_LIMIT);
  localparam logic signed [SUM_W-1:0]  LIM_N   = -LIM_P;
  localparam logic signed [DATA_W-1:0] SCALE_S = DATA_W'(BEHIND_SCALE);

  // matrix rows in the matrix unit
  localparam int ROW_X = 0;
  localparam int ROW_Y = 1;
  localparam int ROW_W = 2;

  // what rides beside the divider
  typedef struct packed {
    logic                     behind;
    logic                     neg_x;
    logic                     neg_y;
    logic signed [DATA_W-1:0] bx;
    logic signed [DATA_W-1:0] by;
  } side_t;

  // behind camera: clip value times the scale, saturated to 32 bits
  function automatic logic signed [DATA_W-1:0] behind_scale(
    input logic signed [SUM_W-1:0] c
  );
    logic signed [DATA_W-1:0] r;
    if (c >= LIM_P) begin
      r = PIX_MAX;
    end else if (c <= LIM_N) begin
      r = PIX_MIN;
    end else begin
      r = DATA_W'($signed(c[BEHIND_IN_W-1:0])) * SCALE_S;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // register file
  // ---------------------------------------------------------------------------
  logic [2:0][CFG_W-1:0]  first_q;
  logic [2:0][CFG_W-1:0]  second_q;
  logic [SIZE_W-1:0]      width_q;
  logic [SIZE_W-1:0]      height_q;
  logic                   cfg_wr;
  logic [REG_IDX_W-1:0]   cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = paddr[ADDR_W-1:ADDR_W-REG_IDX_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q  <= '0;
      second_q <= '0;
      width_q  <= SCREEN_WIDTH_RST;
      height_q <= SCREEN_HEIGHT_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_X_FIRST:  first_q[ROW_X]  <= pwdata;
        REG_X_SECOND: second_q[ROW_X] <= pwdata;
        REG_Y_FIRST:  first_q[ROW_Y]  <= pwdata;
        REG_Y_SECOND: second_q[ROW_Y] <= pwdata;
        REG_W_FIRST:  first_q[ROW_W]  <= pwdata;
        REG_W_SECOND: second_q[ROW_W] <= pwdata;
        REG_WIDTH:    width_q         <= pwdata[SIZE_W-1:0];
        REG_HEIGHT:   height_q        <= pwdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_X_FIRST:  prdata = first_q[ROW_X];
      REG_X_SECOND: prdata = second_q[ROW_X];
      REG_Y_FIRST:  prdata = first_q[ROW_Y];
      REG_Y_SECOND: prdata = second_q[ROW_Y];
      REG_W_FIRST:  prdata = first_q[ROW_W];
      REG_W_SECOND: prdata = second_q[ROW_W];
      REG_WIDTH:    prdata = CFG_W'(width_q);
      REG_HEIGHT:   prdata = CFG_W'(height_q);
      default:      prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // matrix stages: clip x, y, w
  // ---------------------------------------------------------------------------
  logic                    in_acc;
  logic                    mat_valid;
  logic signed [SUM_W-1:0] clip_x;
  logic signed [SUM_W-1:0] clip_y;
  logic signed [SUM_W-1:0] clip_w;

  // the pipeline never stalls, so every start is a transaction
  assign busy   = 1'b0;
  assign in_acc = start & ~busy;

  ppp_matrix #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_matrix (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (in_acc),
    .world_x_i     (world_x_i),
    .world_y_i     (world_y_i),
    .world_z_i     (world_z_i),
    .first_pair_i  (first_q),
    .second_pair_i (second_q),
    .valid_o       (mat_valid),
    .clip_x_o      (clip_x),
    .clip_y_o      (clip_y),
    .clip_w_o      (clip_w)
  );

  // ---------------------------------------------------------------------------
  // preparation stage: near test, behind values, magnitudes for the dividers
  // ---------------------------------------------------------------------------
  side_t            prep_d;
  side_t            prep_q;
  logic             prep_valid_q;
  logic [SUM_W-1:0] mag_x_d;
  logic [SUM_W-1:0] mag_y_d;
  logic [SUM_W-1:0] mag_x_q;
  logic [SUM_W-1:0] mag_y_q;
  logic [SUM_W-1:0] den_q;

  always_comb begin
    prep_d.behind = clip_w < W_MIN;
    prep_d.neg_x  = clip_x[SUM_W-1];
    prep_d.neg_y  = clip_y[SUM_W-1];
    prep_d.bx     = behind_scale(clip_x);
    prep_d.by     = behind_scale(clip_y);
    mag_x_d       = clip_x[SUM_W-1] ? $unsigned(-clip_x) : $unsigned(clip_x);
    mag_y_d       = clip_y[SUM_W-1] ? $unsigned(-clip_y) : $unsigned(clip_y);
  end

  always_ff @(posedge clk_i) begin
    prep_q  <= prep_d;
    mag_x_q <= mag_x_d;
    mag_y_q <= mag_y_d;
    // w is positive whenever the quotient is used
    den_q   <= $unsigned(clip_w);
  end

  // ---------------------------------------------------------------------------
  // dividers, with the side payload delayed alongside
  // ---------------------------------------------------------------------------
  logic [QUOT_BITS:0] quot_x;
  logic [QUOT_BITS:0] quot_y;
  side_t              side_q       [SIDE_LAT];
  logic [SIDE_LAT-1:0] side_valid_q;

  ppp_div #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_div_x (
    .clk_i  (clk_i),
    .mag_i  (mag_x_q),
    .den_i  (den_q),
    .quot_o (quot_x)
  );

  ppp_div #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_div_y (
    .clk_i  (clk_i),
    .mag_i  (mag_y_q),
    .den_i  (den_q),
    .quot_o (quot_y)
  );

  always_ff @(posedge clk_i) begin
    side_q[0] <= prep_q;
    for (int k = 1; k < SIDE_LAT; k++) begin
      side_q[k] <= side_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prep_valid_q <= 1'b0;
      side_valid_q <= '0;
    end else begin
      prep_valid_q <= mat_valid;
      side_valid_q <= {side_valid_q[SIDE_LAT-2:0], prep_valid_q};
    end
  end

  // ---------------------------------------------------------------------------
  // viewport map: x = centre + offset, y = centre - offset
  // ---------------------------------------------------------------------------
  logic signed [DATA_W-1:0] pix_x;
  logic signed [DATA_W-1:0] pix_y;

  ppp_viewport #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_viewport_x (
    .clk_i   (clk_i),
    .quot_i  (quot_x),
    .sub_i   (side_q[DIV_LAT-1].neg_x),
    .size_i  (width_q),
    .pixel_o (pix_x)
  );

  ppp_viewport #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_viewport_y (
    .clk_i   (clk_i),
    .quot_i  (quot_y),
    .sub_i   (~side_q[DIV_LAT-1].neg_y),
    .size_i  (height_q),
    .pixel_o (pix_y)
  );

  // ---------------------------------------------------------------------------
  // result register: one-cycle strobe per transaction
  // ---------------------------------------------------------------------------
  logic                     out_valid_q;
  logic signed [DATA_W-1:0] out_x_q;
  logic signed [DATA_W-1:0] out_y_q;
  logic                     out_front_q;

  always_ff @(posedge clk_i) begin
    if (side_valid_q[SIDE_LAT-1]) begin
      out_x_q     <= side_q[SIDE_LAT-1].behind ? side_q[SIDE_LAT-1].bx : pix_x;
      out_y_q     <= side_q[SIDE_LAT-1].behind ? side_q[SIDE_LAT-1].by : pix_y;
      out_front_q <= ~side_q[SIDE_LAT-1].behind;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= side_valid_q[SIDE_LAT-1];
    end
  end

  assign result_valid_o = out_valid_q;
  assign screen_x_o     = out_x_q;
  assign screen_y_o     = out_y_q;
  assign in_front_o     = out_front_q;

endmodule

`default_nettype wire

@@ hdl/ppp_checker.sv @@
// port-level checks for the point projector and their bind
`default_nettype none

module ppp_checker
  import ppp_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic result_valid_i,
  input logic pready
);

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy)
    else $error("busy raised");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##TOTAL_LAT result_valid_i)
    else $error("transaction without result");

  a_result_has_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_i |-> $past(start && !busy, TOTAL_LAT))
    else $error("result without transaction");

  a_pready_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("pready low");

endmodule

bind perspective_point_projector ppp_checker u_ppp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_i (result_valid_o),
  .pready         (pready)
);

`default_nettype wire

@@ dv/perspective_point_projector_tb.sv @@
// self-checking testbench for the perspective point projector
`timescale 1ns / 1ps

module perspective_point_projector_tb;
  import ppp_pkg::*;

  localparam int     FB          = FRACTION_BITS_DEF;
  // smallest w that still counts as in front, 0.001 in fixed point
  localparam longint NEAR_W_MIN  = ((longint'(1) << FB) + 500) / 1000;
  localparam longint CYCLE_LIMIT = 200000;
  localparam int     REG_COUNT   = 8;
  localparam logic [31:0] ONE_Q  = 32'h0001_0000;

  typedef struct packed {
    logic [DATA_W-1:0] x;
    logic [DATA_W-1:0] y;
    logic [DATA_W-1:0] z;
  } point_t;

  typedef struct packed {
    logic [DATA_W-1:0] sx;
    logic [DATA_W-1:0] sy;
    logic              front;
  } projection_t;

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  always #10 clk_i = ~clk_i;

  // point channel
  logic                     start     = 1'b0;
  logic                     busy;
  logic signed [DATA_W-1:0] world_x_i = '0;
  logic signed [DATA_W-1:0] world_y_i = '0;
  logic signed [DATA_W-1:0] world_z_i = '0;

  // result channel
  logic                     result_valid_o;
  logic signed [DATA_W-1:0] screen_x_o;
  logic signed [DATA_W-1:0] screen_y_o;
  logic                     in_front_o;

  // register port
  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [ADDR_W-1:0] paddr   = '0;
  logic [CFG_W-1:0]  pwdata  = '0;
  logic [CFG_W-1:0]  prdata;
  logic              pready;

  perspective_point_projector dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .world_x_i      (world_x_i),
    .world_y_i      (world_y_i),
    .world_z_i      (world_z_i),
    .result_valid_o (result_valid_o),
    .screen_x_o     (screen_x_o),
    .screen_y_o     (screen_y_o),
    .in_front_o     (in_front_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // shadow copy of the register file, kept in step with every write
  logic [CFG_W-1:0]  matrix_reg [6] = '{default: '0};
  logic [SIZE_W-1:0] width_reg      = SCREEN_WIDTH_RST;
  logic [SIZE_W-1:0] height_reg     = SCREEN_HEIGHT_RST;

  point_t      points_to_send [$];
  projection_t projections_due [$];

  int     idle_pct        = 0;
  bit     took_point      = 1'b0;
  int     points_queued   = 0;
  int     points_taken    = 0;
  int     results_checked = 0;
  int     front_count     = 0;
  int     settings_loaded = 0;
  int     mismatches      = 0;
  longint cycle_count     = 0;

  // ---------------------------------------------------------------------------
  // projection predictor
  // ---------------------------------------------------------------------------

  function automatic logic [DATA_W-1:0] clamp32(longint v);
    if (v > longint'(PIX_MAX)) return PIX_MAX;
    if (v < longint'(PIX_MIN)) return PIX_MIN;
    return v[DATA_W-1:0];
  endfunction

  // one matrix row: each product floored by the fraction bits, column 3 added as is
  function automatic longint row_sum(logic [CFG_W-1:0] lo_pair, logic [CFG_W-1:0] hi_pair,
                                     longint px, longint py, longint pz);
    longint c0, c1, c2, c3;
    c0 = longint'($signed(lo_pair[31:0]));
    c1 = longint'($signed(lo_pair[63:32]));
    c2 = longint'($signed(hi_pair[31:0]));
    c3 = longint'($signed(hi_pair[63:32]));
    return ((c0 * px) >>> FB) + ((c1 * py) >>> FB) + ((c2 * pz) >>> FB) + c3;
  endfunction

  // behind the camera: clip clamped to +-2^31 before scaling
  function automatic logic [DATA_W-1:0] behind_scaled(longint clip);
    longint lim;
    lim = longint'(1) << 31;
    if (clip > lim) clip = lim;
    if (clip < -lim) clip = -lim;
    return clamp32(clip * BEHIND_SCALE);
  endfunction

  // signed half-size pixel offset of clip/w, quotient capped
  function automatic longint pixel_offset(longint clip, longint w, logic [SIZE_W-1:0] size);
    logic [127:0] mag, quot;
    longint       off;
    mag  = (clip < 0) ? 128'(-clip) : 128'(clip);
    quot = (mag << FB) / 128'(w);
    if (quot > (128'(1) << QUOT_BITS)) quot = 128'(1) << QUOT_BITS;
    off = longint'((quot * size) >> 1);
    return (clip < 0) ? -off : off;
  endfunction

  function automatic projection_t project_point(logic signed [DATA_W-1:0] px,
                                                logic signed [DATA_W-1:0] py,
                                                logic signed [DATA_W-1:0] pz);
    projection_t res;
    longint      cx, cy, cw;
    cx = row_sum(matrix_reg[REG_X_FIRST], matrix_reg[REG_X_SECOND], px, py, pz);
    cy = row_sum(matrix_reg[REG_Y_FIRST], matrix_reg[REG_Y_SECOND], px, py, pz);
    cw = row_sum(matrix_reg[REG_W_FIRST], matrix_reg[REG_W_SECOND], px, py, pz);
    if (cw < NEAR_W_MIN) begin
      res.sx    = behind_scaled(cx);
      res.sy    = behind_scaled(cy);
      res.front = 1'b0;
    end else begin
      // centre plus offset for x, centre minus offset for y (screen y grows down)
      res.sx    = clamp32((longint'(width_reg) << (FB - 1)) + pixel_offset(cx, cw, width_reg));
      res.sy    = clamp32((longint'(height_reg) << (FB - 1)) - pixel_offset(cy, cw, height_reg));
      res.front = 1'b1;
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [CFG_W-1:0] want, logic [CFG_W-1:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch on %s at %0t: expected %h, got %h", what, $realtime, want, got);
  endtask

  // ---------------------------------------------------------------------------
  // driver: presents queued points, holding each until the transaction is taken
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin : drive_points
    point_t nxt;
    if (rst_ni && (!start || took_point)) begin
      if (points_to_send.size() != 0 && $urandom_range(99) >= idle_pct) begin
        nxt = points_to_send.pop_front();
        start     <= 1'b1;
        world_x_i <= nxt.x;
        world_y_i <= nxt.y;
        world_z_i <= nxt.z;
      end else begin
        // idle cycle: junk on the data lines must be ignored
        start     <= 1'b0;
        world_x_i <= $urandom;
        world_y_i <= $urandom;
        world_z_i <= $urandom;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: predicts on every accepted point, checks every result transaction
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : watch_results
    projection_t got, want, pred;
    took_point = 1'b0;
    if (rst_ni) begin
      if (start && !busy) begin
        took_point = 1'b1;
        pred = project_point(world_x_i, world_y_i, world_z_i);
        projections_due = {projections_due, pred};
        points_taken++;
      end
      if (result_valid_o === 1'b1) begin
        got = '{sx: screen_x_o, sy: screen_y_o, front: in_front_o};
        if (projections_due.size() == 0) begin
          report_mismatch("unexpected result", '0, {got.sx, got.sy});
        end else begin
          want = projections_due.pop_front();
          results_checked++;
          if (want.front) front_count++;
          if (got.sx !== want.sx)       report_mismatch("screen_x", want.sx, got.sx);
          if (got.sy !== want.sy)       report_mismatch("screen_y", want.sy, got.sy);
          if (got.front !== want.front) report_mismatch("in_front", want.front, got.front);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, projections_due.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // register access
  // ---------------------------------------------------------------------------

  function automatic logic [CFG_W-1:0] reg_value(logic [REG_IDX_W-1:0] idx);
    case (idx)
      REG_WIDTH:  return CFG_W'(width_reg);
      REG_HEIGHT: return CFG_W'(height_reg);
      default:    return matrix_reg[idx];
    endcase
  endfunction

  // registers are 64 bits wide, so they sit on an 8-byte stride
  function automatic logic [ADDR_W-1:0] reg_addr(logic [REG_IDX_W-1:0] idx);
    return ADDR_W'(idx) << 3;
  endfunction

  task automatic reg_write(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = reg_addr(idx);
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    case (idx) inside
      REG_WIDTH:  width_reg  = value[SIZE_W-1:0];
      REG_HEIGHT: height_reg = value[SIZE_W-1:0];
      REG_X_FIRST, REG_X_SECOND, REG_Y_FIRST, REG_Y_SECOND, REG_W_FIRST, REG_W_SECOND:
        matrix_reg[idx] = value;
      default: ;
    endcase
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic reg_read_check(logic [REG_IDX_W-1:0] idx);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = reg_addr(idx);
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    if (prdata !== reg_value(idx)) report_mismatch("register readback", reg_value(idx), prdata);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // writes the full register set, each write read back
  task automatic load_registers(logic [CFG_W-1:0] vals [REG_COUNT]);
    for (int i = 0; i < REG_COUNT; i++) begin
      reg_write(REG_IDX_W'(i), vals[i]);
      reg_read_check(REG_IDX_W'(i));
    end
    settings_loaded++;
  endtask

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic logic [31:0] edge_word();
    case ($urandom_range(5))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      4:       return ONE_Q;
      default: return 32'hFFFF_0000;
    endcase
  endfunction

  // uniform signed value in [-2^b, 2^b)
  function automatic logic [31:0] signed_span(int b);
    logic [31:0] v;
    v = $urandom_range((1 << (b + 1)) - 1, 0);
    return v - (32'd1 << b);
  endfunction

  function automatic logic [31:0] coord_value();
    case ($urandom_range(9)) inside
      0:       return edge_word();
      1, 2:    return $urandom;
      default: return signed_span(23);
    endcase
  endfunction

  task automatic queue_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    point_t p;
    p = '{x: x, y: y, z: z};
    points_to_send = {points_to_send, p};
    points_queued++;
  endtask

  // the block is idle once every queued point has been taken and answered
  task automatic wait_drained();
    while (points_taken != points_queued || results_checked != points_taken)
      @(negedge clk_i);
  endtask

  // kinds: 0 camera-like, 1 all bits random, 2 extreme entries, 3 camera with wide screen
  task automatic load_setting(int kind);
    logic [CFG_W-1:0] vals [REG_COUNT];
    for (int i = 0; i < REG_COUNT; i++) begin
      case (kind)
        1:       vals[i] = {$urandom, $urandom};
        2:       vals[i] = {edge_word(), edge_word()};
        default: vals[i] = {signed_span(20), signed_span(18)};
      endcase
    end
    if (kind != 1 && kind != 2) begin
      // w tracks z with a little tilt, so points land on both sides of the near plane
      vals[REG_W_SECOND] = {signed_span(16), ONE_Q + signed_span(14)};
    end
    case (kind)
      0: begin
        vals[REG_WIDTH]  = CFG_W'($urandom_range(8192, 1));
        vals[REG_HEIGHT] = CFG_W'($urandom_range(8192, 1));
      end
      2: begin
        vals[REG_WIDTH]  = ($urandom_range(1)) ? CFG_W'(8192) : CFG_W'(1);
        vals[REG_HEIGHT] = ($urandom_range(1)) ? CFG_W'(0) : CFG_W'(16383);
      end
      3: begin
        vals[REG_WIDTH]  = CFG_W'($urandom_range(16383, 8193));
        vals[REG_HEIGHT] = CFG_W'($urandom_range(16383, 8193));
      end
      default: ;
    endcase
    load_registers(vals);
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin : run_test
    logic [CFG_W-1:0] vals [REG_COUNT];
    int idle_plan [6];
    idle_plan = '{0, 60, 36, 60, 36, 0};

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset values must read back before anything is written
    for (int i = 0; i < REG_COUNT; i++) reg_read_check(REG_IDX_W'(i));

    // with the reset matrix w is zero, so everything is behind and maps to zero
    idle_pct = 0;
    queue_point(32'h0, 32'h0, 32'h0);
    queue_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    queue_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    queue_point($urandom, $urandom, $urandom);
    wait_drained();

    // identity view, w = z
    vals = '{default: '0};
    vals[REG_X_FIRST]  = {32'h0, ONE_Q};
    vals[REG_Y_FIRST]  = {ONE_Q, 32'h0};
    vals[REG_W_SECOND] = {32'h0, ONE_Q};
    vals[REG_WIDTH]    = CFG_W'(1920);
    vals[REG_HEIGHT]   = CFG_W'(1080);
    load_registers(vals);
    queue_point(32'h0, 32'h0, ONE_Q);                      // screen centre
    queue_point(ONE_Q, 32'hFFFF_0000, ONE_Q);              // lower right corner
    queue_point(32'h7FFF_FFFF, 32'h8000_0000, 32'd65);     // just behind, saturates both ways
    queue_point(ONE_Q, ONE_Q, 32'd66);                     // exactly on the near plane
    queue_point(32'h0, 32'h0, 32'h0);                      // w zero
    queue_point(32'd5, 32'hFFFF_FFF9, 32'hFFFF_0000);      // negative w, small scaled clip
    queue_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    queue_point(32'hFFFF_FFFF, 32'h1, 32'h7FFF_FFFF);
    queue_point(32'h0002_0000, 32'h0000_8000, 32'h0004_0000);
    queue_point(32'h1234_5678, 32'hEDCB_A987, 32'h0010_0000);
    wait_drained();

    // huge clip against the smallest w drives the quotient into its cap;
    // an all-ones write checks size masking, zero height collapses y
    vals[REG_X_FIRST] = {32'h0, 32'h7FFF_FFFF};
    vals[REG_Y_FIRST] = {32'h8000_0000, 32'h0};
    vals[REG_WIDTH]   = '1;
    vals[REG_HEIGHT]  = '0;
    load_registers(vals);
    queue_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd66);
    queue_point(32'h8000_0000, ONE_Q, 32'd66);
    queue_point(32'h1, 32'h1, ONE_Q);
    queue_point(32'h7FFF_FFFF, 32'h8000_0000, 32'd65);     // behind with clip past 2^31
    queue_point(32'hFFFF_0000, 32'hFFFF_0000, 32'h7FFF_FFFF);
    queue_point(32'h0, 32'h0, 32'h4000_0000);
    wait_drained();

    // random phases: each loads a fresh setting and runs with its own gap rate
    for (int ph = 0; ph < 6; ph++) begin
      load_setting(ph % 4);
      idle_pct = idle_plan[ph];
      for (int n = 0; n < 135; n++) queue_point(coord_value(), coord_value(), coord_value());
      wait_drained();
    end

    // let any stray result surface before the verdict
    repeat (TOTAL_LAT + 4) @(posedge clk_i);
    if (projections_due.size() != 0)
      report_mismatch("results never delivered", '0, CFG_W'(projections_due.size()));

    $display("projected %0d points (%0d in front, %0d behind) across %0d register settings",
             results_checked, front_count, results_checked - front_count, settings_loaded);
    $display("sender gap rates of 0, 36 and 60 percent; %0d mismatches in %0d cycles",
             mismatches, cycle_count);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
